>>> sv/fch_pkg.sv
package fch_pkg;

   // curve geometry
   localparam int MAX_POINTS = 8;
   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_IDX_W = 3;

   // field widths
   localparam int TEMP_RAW_W = 18;
   localparam int TEMP_W     = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // serial divider sizing
   localparam int DIVIDEND_W = 18;
   localparam int DIVISOR_W  = 10;

   // constants
   localparam logic [9:0] MILLI_PER_DEG = 10'd1000;
   localparam logic [6:0] PCT_FULL      = 7'd100;
   localparam logic signed [3:0] SEG_NONE = -4'sd1;

   typedef enum logic [2:0] {
      REG_POINTS_LOW,
      REG_POINTS_HIGH,
      REG_POINT_COUNT,
      REG_HYSTERESIS,
      REG_THROTTLE,
      REG_PWM_MIN,
      REG_PWM_MAX
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_EMPTY,
      STATUS_SENSOR
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_TEMP,
      S_FIRST,
      S_LAST,
      S_SEARCH,
      S_MUL,
      S_DIV_INTERP,
      S_HELD,
      S_PWM_MUL,
      S_DIV_PWM,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][7:0] temp;
      logic [NUM_SLOTS-1:0][6:0] speed;
      logic [3:0]                count;
      logic [7:0]                hyst;
      logic                      throttle;
      logic [7:0]                pwm_min;
      logic [7:0]                pwm_max;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> sv/fch_if.sv
interface fch_req_if;
   logic                           valid;
   logic                           ready;
   logic [fch_pkg::TEMP_RAW_W-1:0] temp_millideg;
   logic                           sensor_error;

   modport source (output valid, output temp_millideg, output sensor_error, input ready);
   modport sink (input valid, input temp_millideg, input sensor_error, output ready);
endinterface

interface fch_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        pwm_value;
   logic [6:0]        speed_percent;
   logic signed [3:0] active_segment;
   logic [1:0]        status;

   modport source (output valid, output pwm_value, output speed_percent,
                   output active_segment, output status, input ready);
   modport sink (input valid, input pwm_value, input speed_percent,
                 input active_segment, input status, output ready);
endinterface

interface fch_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fch_pkg::CSR_IDX_W-1:0]  index;
   logic [fch_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/fch_regs.sv
module fch_regs #(
   parameter int MAX_POINTS = fch_pkg::MAX_POINTS
) (
   input  logic             clock,
   input  logic             reset,
   fch_csr_if.sink          csr_chan,
   output fch_pkg::cfg_type cfg,
   output logic             cfg_hit
);

   localparam logic [3:0] COUNT_CAP = 4'(MAX_POINTS);

   logic [63:0] low_ff, low_in, high_ff, high_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  hyst_ff, hyst_in;
   logic        throttle_ff, throttle_in;
   logic [7:0]  pwm_min_ff, pwm_min_in;
   logic [7:0]  pwm_max_ff, pwm_max_in;
   logic [2*64-1:0] points;
   logic [7:0]      raw_speed;

   assign csr_chan.ready = 1'b1;

   // register writes, count saturates at the curve capacity
   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      count_in    = count_ff;
      hyst_in     = hyst_ff;
      throttle_in = throttle_ff;
      pwm_min_in  = pwm_min_ff;
      pwm_max_in  = pwm_max_ff;
      cfg_hit     = 1'b0;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            fch_pkg::REG_POINTS_LOW: begin
               low_in  = csr_chan.data;
               cfg_hit = 1'b1;
            end
            fch_pkg::REG_POINTS_HIGH: begin
               high_in = csr_chan.data;
               cfg_hit = 1'b1;
            end
            fch_pkg::REG_POINT_COUNT: begin
               count_in = (csr_chan.data[3:0] > COUNT_CAP) ? COUNT_CAP : csr_chan.data[3:0];
               cfg_hit  = 1'b1;
            end
            fch_pkg::REG_HYSTERESIS: begin
               hyst_in = csr_chan.data[7:0];
               cfg_hit = 1'b1;
            end
            fch_pkg::REG_THROTTLE: begin
               throttle_in = csr_chan.data[0];
               cfg_hit     = 1'b1;
            end
            fch_pkg::REG_PWM_MIN: begin
               pwm_min_in = csr_chan.data[7:0];
               cfg_hit    = 1'b1;
            end
            fch_pkg::REG_PWM_MAX: begin
               pwm_max_in = csr_chan.data[7:0];
               cfg_hit    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= '0;
         high_ff     <= '0;
         count_ff    <= '0;
         hyst_ff     <= '0;
         throttle_ff <= 1'b0;
         pwm_min_ff  <= 8'h00;
         pwm_max_ff  <= 8'hFF;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         count_ff    <= count_in;
         hyst_ff     <= hyst_in;
         throttle_ff <= throttle_in;
         pwm_min_ff  <= pwm_min_in;
         pwm_max_ff  <= pwm_max_in;
      end
   end

   // unpack points, speeds above full scale clip to full scale
   assign points = {high_ff, low_ff};

   always_comb begin
      raw_speed = '0;
      for (int k = 0; k < fch_pkg::NUM_SLOTS; k++) begin
         raw_speed        = points[16*k+8 +: 8];
         cfg.temp[k]      = points[16*k +: 8];
         cfg.speed[k]     = (raw_speed > {1'b0, fch_pkg::PCT_FULL}) ?
                            fch_pkg::PCT_FULL : raw_speed[6:0];
      end
      cfg.count    = count_ff;
      cfg.hyst     = hyst_ff;
      cfg.throttle = throttle_ff;
      cfg.pwm_min  = pwm_min_ff;
      cfg.pwm_max  = pwm_max_ff;
   end

endmodule

>>> sv/fch_sdiv.sv
module fch_sdiv #(
   parameter int DIVIDEND_W = fch_pkg::DIVIDEND_W,
   parameter int DIVISOR_W  = fch_pkg::DIVISOR_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output fch_pkg::div_stat_type stat,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_diff;
   logic                  fits;

   // one restoring step per cycle, dividend bits shift out as quotient bits shift in
   assign trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits       = trial >= {1'b0, dsr_ff};
   assign trial_diff = trial - {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/fan_curve_with_hysteresis_unit.sv
// channel  dir  handshake    word
// -------  ---  -----------  -----------------------------------------------
// req      in   valid/ready  temp_millideg, sensor_error
// rsp      out  valid/ready  pwm_value, speed_percent, active_segment, status
// csr      in   valid/ready  index, data (register write, always ready)
//
// an ok word makes up to three passes through the shared radix-2 divider
// (18 steps each: millidegree, interpolation and pwm divisions) and scans
// the curve points one by one; the interpolation divide is skipped when no
// segment brackets the temperature. error words (empty curve, sensor error) skip the divider.
// synchronous reset, no clearing pass; held segment comes up as -1.
// a stalled rsp holds its word; the next req word is taken and waits finished.
module fan_curve_with_hysteresis_unit #(
   parameter int MAX_POINTS = fch_pkg::MAX_POINTS
) (
   input logic        clock,
   input logic        reset,
   fch_req_if.sink    req_chan,
   fch_rsp_if.source  rsp_chan,
   fch_csr_if.sink    csr_chan
);

   localparam int DVD_W = fch_pkg::DIVIDEND_W;
   localparam int DVS_W = fch_pkg::DIVISOR_W;
   localparam int IDX_W = fch_pkg::SLOT_IDX_W;

   fch_pkg::cfg_type      cfg;
   logic                  cfg_hit;
   fch_pkg::div_stat_type div_stat;
   logic                  div_start;
   logic [DVD_W-1:0]      div_dividend;
   logic [DVS_W-1:0]      div_divisor;
   logic [DVD_W-1:0]      div_quo;
   logic [DVS_W-1:0]      div_rem;

   fch_pkg::state_type state_ff, state_in;
   logic [fch_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [7:0]        prev_t_ff, prev_t_in;
   logic [6:0]        prev_s_ff, prev_s_in;
   logic [6:0]        speed_ff, speed_in;
   logic signed [3:0] seg_ff, seg_in;
   logic signed [3:0] held_ff, held_in;
   logic              neg_ff, neg_in;
   logic [6:0]        mag_ds_ff, mag_ds_in;
   logic [7:0]        dx_ff, dx_in;
   logic [7:0]        dt_ff, dt_in;
   logic [7:0]        res_pwm_ff, res_pwm_in;
   logic [1:0]        res_status_ff, res_status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_pwm_ff, rsp_pwm_in;
   logic [6:0]        rsp_speed_ff, rsp_speed_in;
   logic signed [3:0] rsp_seg_ff, rsp_seg_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]  pt_idx;
   logic [7:0]        pt_t;
   logic [6:0]        pt_s;
   logic [IDX_W-1:0]  last_idx;
   logic [7:0]        mul_a, mul_b;
   logic [15:0]       mul_p;
   logic [8:0]        adj;
   logic [9:0]        pwm_sum;
   logic [7:0]        mag_diff;
   logic              range_neg;
   logic              seg_hit;
   logic              keep_held;
   logic              out_load;

   fch_regs #(.MAX_POINTS(MAX_POINTS)) u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg),
      .cfg_hit  (cfg_hit)
   );

   fch_sdiv #(.DIVIDEND_W(DVD_W), .DIVISOR_W(DVS_W)) u_sdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // single point read port
   always_comb begin
      case (state_ff)
         fch_pkg::S_LAST:   pt_idx = last_idx;
         fch_pkg::S_SEARCH: pt_idx = i_ff;
         fch_pkg::S_HELD:   pt_idx = held_ff[IDX_W-1:0];
         default:           pt_idx = '0;
      endcase
   end

   assign pt_t     = cfg.temp[pt_idx];
   assign pt_s     = cfg.speed[pt_idx];
   assign last_idx = IDX_W'(cfg.count - 4'd1);

   // shared multiplier for interpolation and pwm scaling
   assign range_neg = cfg.pwm_max < cfg.pwm_min;
   assign mag_diff  = range_neg ? (cfg.pwm_min - cfg.pwm_max) : (cfg.pwm_max - cfg.pwm_min);
   assign mul_a     = (state_ff == fch_pkg::S_MUL) ? {1'b0, mag_ds_ff} : mag_diff;
   assign mul_b     = (state_ff == fch_pkg::S_MUL) ? dx_ff : {1'b0, speed_ff};
   assign mul_p     = mul_a * mul_b;

   // floor correction: negative quotients round away from zero on a remainder
   assign adj     = {1'b0, div_quo[7:0]} + 9'(neg_ff && (div_rem != '0));
   assign pwm_sum = neg_ff ? ({2'b00, cfg.pwm_min} - {1'b0, adj}) :
                             ({2'b00, cfg.pwm_min} + {1'b0, adj});

   // segment tests
   assign seg_hit = ({1'b0, prev_t_ff} < temp_ff) && (temp_ff <= {1'b0, pt_t});
   assign keep_held = !held_ff[3] && ({1'b0, held_ff[IDX_W-1:0]} < cfg.count) &&
                      (seg_ff < held_ff) &&
                      (({1'b0, temp_ff} + {2'b00, cfg.hyst}) > {2'b00, pt_t});

   assign out_load = (state_ff == fch_pkg::S_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == fch_pkg::S_IDLE);

   // sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      temp_in       = temp_ff;
      i_in          = i_ff;
      prev_t_in     = prev_t_ff;
      prev_s_in     = prev_s_ff;
      speed_in      = speed_ff;
      seg_in        = seg_ff;
      held_in       = held_ff;
      neg_in        = neg_ff;
      mag_ds_in     = mag_ds_ff;
      dx_in         = dx_ff;
      dt_in         = dt_ff;
      res_pwm_in    = res_pwm_ff;
      res_status_in = res_status_ff;
      div_start     = 1'b0;
      div_dividend  = DVD_W'(mul_p);
      div_divisor   = DVS_W'(dt_ff);
      case (state_ff)
         fch_pkg::S_IDLE: begin
            div_dividend = DVD_W'(req_chan.temp_millideg);
            div_divisor  = DVS_W'(fch_pkg::MILLI_PER_DEG);
            if (req_chan.valid) begin
               if (cfg.count == 4'd0) begin
                  res_status_in = fch_pkg::STATUS_EMPTY;
                  res_pwm_in    = '0;
                  speed_in      = '0;
                  state_in      = fch_pkg::S_OUT;
               end else if (req_chan.sensor_error) begin
                  res_status_in = fch_pkg::STATUS_SENSOR;
                  res_pwm_in    = '0;
                  speed_in      = '0;
                  state_in      = fch_pkg::S_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = fch_pkg::S_DIV_TEMP;
               end
            end
         end
         fch_pkg::S_DIV_TEMP: begin
            if (div_stat.done) begin
               temp_in  = div_quo[fch_pkg::TEMP_W-1:0];
               state_in = fch_pkg::S_FIRST;
            end
         end
         fch_pkg::S_FIRST: begin
            prev_t_in = pt_t;
            prev_s_in = pt_s;
            if (temp_ff <= {1'b0, pt_t}) begin
               seg_in   = fch_pkg::SEG_NONE;
               speed_in = cfg.throttle ? 7'd0 : pt_s;
               state_in = fch_pkg::S_HELD;
            end else begin
               state_in = fch_pkg::S_LAST;
            end
         end
         fch_pkg::S_LAST: begin
            speed_in = pt_s;
            if (temp_ff > {1'b0, pt_t}) begin
               seg_in   = signed'({1'b0, last_idx});
               state_in = fch_pkg::S_HELD;
            end else begin
               i_in     = IDX_W'(1);
               state_in = fch_pkg::S_SEARCH;
            end
         end
         fch_pkg::S_SEARCH: begin
            if (seg_hit) begin
               seg_in    = signed'({1'b0, IDX_W'(i_ff - 1'b1)});
               neg_in    = pt_s < prev_s_ff;
               mag_ds_in = (pt_s < prev_s_ff) ? (prev_s_ff - pt_s) : (pt_s - prev_s_ff);
               dt_in     = pt_t - prev_t_ff;
               dx_in     = 8'(temp_ff - {1'b0, prev_t_ff});
               state_in  = fch_pkg::S_MUL;
            end else if (i_ff == last_idx) begin
               // unordered curve, no bracketing pair: last point's speed stands
               seg_in   = fch_pkg::SEG_NONE;
               state_in = fch_pkg::S_HELD;
            end else begin
               prev_t_in = pt_t;
               prev_s_in = pt_s;
               i_in      = i_ff + 1'b1;
            end
         end
         fch_pkg::S_MUL: begin
            div_start = 1'b1;
            state_in  = fch_pkg::S_DIV_INTERP;
         end
         fch_pkg::S_DIV_INTERP: begin
            if (div_stat.done) begin
               speed_in = neg_ff ? (prev_s_ff - adj[6:0]) : (prev_s_ff + adj[6:0]);
               state_in = fch_pkg::S_HELD;
            end
         end
         fch_pkg::S_HELD: begin
            if (keep_held) begin
               speed_in = pt_s;
            end else begin
               held_in = seg_ff;
            end
            state_in = fch_pkg::S_PWM_MUL;
         end
         fch_pkg::S_PWM_MUL: begin
            neg_in      = range_neg;
            div_start   = 1'b1;
            div_divisor = DVS_W'(fch_pkg::PCT_FULL);
            state_in    = fch_pkg::S_DIV_PWM;
         end
         fch_pkg::S_DIV_PWM: begin
            if (div_stat.done) begin
               res_pwm_in    = pwm_sum[7:0];
               res_status_in = fch_pkg::STATUS_OK;
               state_in      = fch_pkg::S_OUT;
            end
         end
         fch_pkg::S_OUT: begin
            if (out_load) begin
               state_in = fch_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fch_pkg::S_IDLE;
         end
      endcase
      // any register write drops the held segment
      if (cfg_hit) begin
         held_in = fch_pkg::SEG_NONE;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_pwm_in    = rsp_pwm_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_status_in = rsp_status_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_pwm_in    = res_pwm_ff;
         rsp_speed_in  = speed_ff;
         rsp_seg_in    = held_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      temp_in_reg: begin
         temp_ff       <= temp_in;
         i_ff          <= i_in;
         prev_t_ff     <= prev_t_in;
         prev_s_ff     <= prev_s_in;
         speed_ff      <= speed_in;
         seg_ff        <= seg_in;
         neg_ff        <= neg_in;
         mag_ds_ff     <= mag_ds_in;
         dx_ff         <= dx_in;
         dt_ff         <= dt_in;
         res_pwm_ff    <= res_pwm_in;
         res_status_ff <= res_status_in;
         rsp_pwm_ff    <= rsp_pwm_in;
         rsp_speed_ff  <= rsp_speed_in;
         rsp_seg_ff    <= rsp_seg_in;
         rsp_status_ff <= rsp_status_in;
      end
      if (reset) begin
         state_ff     <= fch_pkg::S_IDLE;
         held_ff      <= fch_pkg::SEG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pwm_value      = rsp_pwm_ff;
   assign rsp_chan.speed_percent  = rsp_speed_ff;
   assign rsp_chan.active_segment = rsp_seg_ff;
   assign rsp_chan.status         = rsp_status_ff;

`ifndef SYNTHESIS
   // divider finishes only while the sequencer waits on it
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == fch_pkg::S_DIV_TEMP ||
                         state_ff == fch_pkg::S_DIV_INTERP ||
                         state_ff == fch_pkg::S_DIV_PWM))
      else $error("divider result with no waiting state");

   // no restart of a running division
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // interpolated speed stays within full scale
   a_interp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fch_pkg::S_DIV_INTERP && div_stat.done) |=>
         (speed_ff <= fch_pkg::PCT_FULL))
      else $error("interpolated speed out of range");

   // a register write leaves no segment held
   a_cfg_clears_held: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (held_ff == fch_pkg::SEG_NONE))
      else $error("held segment survived a register write");

   // error words carry zero drive
   a_error_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != fch_pkg::STATUS_OK) |->
         (rsp_pwm_ff == 8'd0 && rsp_speed_ff == 7'd0))
      else $error("error word with nonzero drive");
`endif

endmodule
